// ===== sv/signed_binary_to_decimal_ascii_top_macros.svh =====
// Assertion macros for the file that checks its own logic.
`ifndef SIGNED_BINARY_TO_DECIMAL_ASCII_TOP_MACROS_SVH
`define SIGNED_BINARY_TO_DECIMAL_ASCII_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBDASC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SBDASC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sbdasc_pkg.sv =====
package sbdasc_pkg;

  localparam int DEFAULT_VALUE_WIDTH = 64;
  localparam int INPUT_WIDTH = 64;
  localparam int CHAR_WIDTH = 8;
  localparam int DIGIT_WIDTH = 4;

  localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO = 8'd48;
  localparam logic [CHAR_WIDTH-1:0] ASCII_MINUS = 8'd45;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic shift_out;
  } bcd_ctrl_t;

endpackage

// ===== sv/sbdasc_bcd.sv =====
module sbdasc_bcd #(
  parameter int VALUE_WIDTH = sbdasc_pkg::DEFAULT_VALUE_WIDTH,
  parameter int DIGITS = 19
) (
  input  logic                                clk,
  input  sbdasc_pkg::bcd_ctrl_t               ctrl,
  input  logic [VALUE_WIDTH-1:0]              load_mag,
  output logic [sbdasc_pkg::DIGIT_WIDTH-1:0]  top_digit
);

  localparam int DW = sbdasc_pkg::DIGIT_WIDTH;
  localparam int BW = DIGITS * DW;

  logic [VALUE_WIDTH-1:0] mag;
  logic [BW-1:0]          bcd;
  logic [BW-1:0]          adjusted;

  // Before each shift, every digit of five or more is corrected by three.
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[i*DW +: DW] >= DW'(5)) begin
        adjusted[i*DW +: DW] = bcd[i*DW +: DW] + DW'(3);
      end else begin
        adjusted[i*DW +: DW] = bcd[i*DW +: DW];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mag <= load_mag;
      bcd <= '0;
    end else if (ctrl.step) begin
      mag <= {mag[VALUE_WIDTH-2:0], 1'b0};
      bcd <= {adjusted[BW-2:0], mag[VALUE_WIDTH-1]};
    end else if (ctrl.shift_out) begin
      bcd <= {bcd[BW-DW-1:0], {DW{1'b0}}};
    end
  end

  assign top_digit = bcd[BW-1 -: DW];

endmodule

// ===== sv/signed_binary_to_decimal_ascii_top.sv =====
// Converts a signed two's complement value (the low VALUE_WIDTH bits of value) to
// its decimal text, one ASCII character per strobe, most significant first, with
// last_char set on the final character; negative values begin with '-'. A
// transaction starts when start is high while busy is low. The magnitude goes
// through a double-dabble BCD shift register one bit per cycle, then the digits
// shift out one per cycle (leading zeros dropped without a strobe); busy stays
// high until the last digit has been emitted, so a new value can start only after
// the previous one is through. The characters appear at their own pace and must be
// taken as they come, since the receiver cannot stall them.
module signed_binary_to_decimal_ascii_top #(
  parameter int VALUE_WIDTH = sbdasc_pkg::DEFAULT_VALUE_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [sbdasc_pkg::INPUT_WIDTH-1:0]   value,
  output logic                                 strobe,
  output logic [sbdasc_pkg::CHAR_WIDTH-1:0]    text_char,
  output logic                                 last_char
);

  `include "signed_binary_to_decimal_ascii_top_macros.svh"

  localparam int DIGITS = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
  localparam int CW = $clog2(VALUE_WIDTH);
  localparam int NW = $clog2(DIGITS + 1);

  sbdasc_pkg::state_t state;
  sbdasc_pkg::state_t state_next;

  logic [CW-1:0]          bit_cnt;
  logic [NW-1:0]          dig_cnt;
  logic                   sign_pend;
  logic                   started;
  logic [VALUE_WIDTH-1:0] value_w;
  logic [VALUE_WIDTH-1:0] load_mag;
  logic                   accept;
  logic                   conv_done;
  logic                   emit_skip;
  logic                   emit_valid;
  logic                   emit_last;
  logic [sbdasc_pkg::CHAR_WIDTH-1:0]  emit_char;
  logic [sbdasc_pkg::DIGIT_WIDTH-1:0] top_digit;
  sbdasc_pkg::bcd_ctrl_t  ctrl;

  assign value_w   = value[VALUE_WIDTH-1:0];
  assign load_mag  = value_w[VALUE_WIDTH-1] ? (~value_w + 1'b1) : value_w;
  assign busy      = (state != sbdasc_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign conv_done = (bit_cnt == CW'(VALUE_WIDTH - 1));
  assign emit_skip = !started && (top_digit == '0) && (dig_cnt != NW'(1));

  always_comb begin
    state_next = state;
    case (state)
      sbdasc_pkg::ST_IDLE: begin
        if (start) begin
          state_next = sbdasc_pkg::ST_CONV;
        end
      end
      sbdasc_pkg::ST_CONV: begin
        if (conv_done) begin
          state_next = sbdasc_pkg::ST_EMIT;
        end
      end
      sbdasc_pkg::ST_EMIT: begin
        if (dig_cnt == NW'(1)) begin
          state_next = sbdasc_pkg::ST_IDLE;
        end
      end
      default: state_next = sbdasc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl       = '0;
    emit_valid = 1'b0;
    emit_last  = 1'b0;
    emit_char  = sbdasc_pkg::ASCII_ZERO;
    case (state)
      sbdasc_pkg::ST_IDLE: begin
        ctrl.load = accept;
      end
      sbdasc_pkg::ST_CONV: begin
        ctrl.step = 1'b1;
        if (sign_pend) begin
          emit_valid = 1'b1;
          emit_char  = sbdasc_pkg::ASCII_MINUS;
        end
      end
      sbdasc_pkg::ST_EMIT: begin
        ctrl.shift_out = 1'b1;
        emit_valid     = !emit_skip;
        emit_last      = (dig_cnt == NW'(1));
        emit_char      = sbdasc_pkg::ASCII_ZERO
                         + {{(sbdasc_pkg::CHAR_WIDTH - sbdasc_pkg::DIGIT_WIDTH){1'b0}},
                            top_digit};
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sbdasc_pkg::ST_IDLE;
      strobe    <= 1'b0;
      sign_pend <= 1'b0;
      started   <= 1'b0;
      bit_cnt   <= '0;
      dig_cnt   <= '0;
    end else begin
      state  <= state_next;
      strobe <= emit_valid;
      if (accept) begin
        sign_pend <= value_w[VALUE_WIDTH-1];
        started   <= 1'b0;
        bit_cnt   <= '0;
        dig_cnt   <= NW'(DIGITS);
      end else if (state == sbdasc_pkg::ST_CONV) begin
        sign_pend <= 1'b0;
        bit_cnt   <= bit_cnt + 1'b1;
      end else if (state == sbdasc_pkg::ST_EMIT) begin
        dig_cnt <= dig_cnt - 1'b1;
        if (!emit_skip) begin
          started <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    text_char <= emit_char;
    last_char <= emit_last;
  end

  sbdasc_bcd #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .DIGITS      (DIGITS)
  ) u_bcd (
    .clk       (clk),
    .ctrl      (ctrl),
    .load_mag  (load_mag),
    .top_digit (top_digit)
  );

  `SBDASC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not set busy")
  `SBDASC_ASSERT_SAME(a_last_idle, strobe && last_char, !busy, "final character while still busy")
  `SBDASC_ASSERT_SAME(a_mid_busy, strobe && !last_char, busy, "inner character while idle")
  `SBDASC_ASSERT_SAME(a_emit_cnt, state == sbdasc_pkg::ST_EMIT, dig_cnt != '0, "digit count ran out")

endmodule

// ===== tb/sv/signed_binary_to_decimal_ascii_top_test.sv =====
module signed_binary_to_decimal_ascii_top_test;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 100;
  localparam int DIRECTED_COUNT = 24;
  localparam int RANDOM_PER_PHASE = 49;

  typedef struct packed {
    logic [sbdasc_pkg::CHAR_WIDTH-1:0] text_char;
    logic                              last_char;
  } ascii_char_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               start = 1'b0;
  logic [sbdasc_pkg::INPUT_WIDTH-1:0] value = '0;
  logic                               busy;
  logic                               strobe;
  logic [sbdasc_pkg::CHAR_WIDTH-1:0]  text_char;
  logic                               last_char;

  ascii_char_t expected_chars[$];
  int          sender_idle_pct = 0;
  int          values_converted = 0;
  int          negative_values = 0;
  int          chars_checked = 0;
  int          mismatches = 0;
  int          stall_cycles = 0;

  logic [sbdasc_pkg::INPUT_WIDTH-1:0] directed_value [DIRECTED_COUNT];
  string                              directed_text [DIRECTED_COUNT];

  signed_binary_to_decimal_ascii_top dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .value     (value),
    .strobe    (strobe),
    .text_char (text_char),
    .last_char (last_char)
  );

  always #1 clk = ~clk;

  task automatic predict_decimal_text(input logic [sbdasc_pkg::INPUT_WIDTH-1:0] v);
    logic [sbdasc_pkg::INPUT_WIDTH-1:0] magnitude;
    logic [sbdasc_pkg::INPUT_WIDTH-1:0] remainder;
    logic [sbdasc_pkg::CHAR_WIDTH-1:0]  digits[$];
    ascii_char_t                        c;
    magnitude = v[sbdasc_pkg::INPUT_WIDTH-1] ? (~v + 1'b1) : v;
    do begin
      remainder = magnitude % 10;
      digits.push_front(sbdasc_pkg::ASCII_ZERO + remainder[sbdasc_pkg::CHAR_WIDTH-1:0]);
      magnitude = magnitude / 10;
    end while (magnitude != 0);
    if (v[sbdasc_pkg::INPUT_WIDTH-1]) begin
      c.text_char = sbdasc_pkg::ASCII_MINUS;
      c.last_char = 1'b0;
      expected_chars.push_back(c);
    end
    foreach (digits[i]) begin
      c.text_char = digits[i];
      c.last_char = (i == digits.size() - 1);
      expected_chars.push_back(c);
    end
  endtask

  task automatic expect_typed_text(input string s);
    ascii_char_t c;
    for (int i = 0; i < s.len(); i++) begin
      c.text_char = s[i];
      c.last_char = (i == s.len() - 1);
      expected_chars.push_back(c);
    end
  endtask

  // The expectation is queued in the time step of the accepting edge, before any of
  // its characters can be strobed.
  task automatic convert_value(input logic [sbdasc_pkg::INPUT_WIDTH-1:0] v,
                               input string typed);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      value <= {$urandom, $urandom};
      @(posedge clk);
    end
    start <= 1'b1;
    value <= v;
    do @(posedge clk); while (busy);
    if (typed.len() > 0) begin
      expect_typed_text(typed);
    end else begin
      predict_decimal_text(v);
    end
    values_converted++;
    if (v[sbdasc_pkg::INPUT_WIDTH-1]) begin
      negative_values++;
    end
  endtask

  function automatic logic [sbdasc_pkg::INPUT_WIDTH-1:0] random_value();
    logic [sbdasc_pkg::INPUT_WIDTH-1:0] r;
    r = {$urandom, $urandom};
    if ($urandom_range(0, 3) != 0) begin
      r = r >> $urandom_range(0, sbdasc_pkg::INPUT_WIDTH - 1);
      if ($urandom_range(0, 1) == 1) begin
        r = -r;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    ascii_char_t want;
    if (!rst && strobe) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected character %0d with last_char %0b", text_char, last_char);
        mismatches++;
      end else begin
        want = expected_chars.pop_front();
        chars_checked++;
        if (text_char !== want.text_char) begin
          $error("text_char mismatch: expected %0d, got %0d", want.text_char, text_char);
          mismatches++;
        end
        if (last_char !== want.last_char) begin
          $error("last_char mismatch: expected %0b, got %0b", want.last_char, last_char);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || strobe || (start && !busy)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles.", STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    directed_value = '{
      64'd0, 64'd1, -64'sd1, 64'd9, 64'd10, -64'sd10, 64'd99, 64'd100,
      64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
      64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFE,
      64'd999999999999999999, 64'd1000000000000000000,
      -64'sd1000000000000000000, -64'sd2,
      64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
      64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000,
      64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
      64'd12345, -64'sd12345
    };
    directed_text = '{
      "0", "1", "-1", "9", "10", "-10", "99", "100",
      "9223372036854775807", "-9223372036854775808",
      "-9223372036854775807", "9223372036854775806",
      "999999999999999999", "1000000000000000000",
      "-1000000000000000000", "-2",
      "", "", "", "", "", "", "", ""
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    sender_idle_pct = 36;
    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      convert_value(directed_value[i], directed_text[i]);
    end
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 77 : 0;
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        convert_value(random_value(), "");
      end
    end
    start <= 1'b0;

    while (expected_chars.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d values (%0d negative), checked %0d characters.",
             values_converted, negative_values, chars_checked);
    $display("Covered zero, both extremes, digit-count boundaries and three idle mixes.");
    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
